FILE: sv/pdc_pkg.sv
package pdc_pkg;

    localparam int unsigned SQ_DIM    = 5;
    localparam int unsigned CODE_W    = 5;
    localparam int unsigned ROW_W     = SQ_DIM * CODE_W;
    localparam int unsigned IDX_W     = 3;

    localparam logic [CODE_W-1:0] CODE_I   = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J   = 5'd9;
    localparam logic [CODE_W-1:0] CODE_MAX = 5'd25;

    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd4;

    typedef logic [CODE_W-1:0] letter_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Per-row search result of one lane
    typedef struct packed {
        logic hit_a;
        idx_t col_a;
        logic hit_b;
        idx_t col_b;
    } lane_hit_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ROW_A = 3'd0,
        REG_ROW_B = 3'd1,
        REG_ROW_C = 3'd2,
        REG_ROW_D = 3'd3,
        REG_ROW_E = 3'd4
    } reg_idx_t;

    // Letter code stored in the given column of a row
    function automatic letter_t cell_of(input row_t row, input idx_t col);
        letter_t res;
        res = '0;
        case (col)
            3'd0:    res = row[0*CODE_W +: CODE_W];
            3'd1:    res = row[1*CODE_W +: CODE_W];
            3'd2:    res = row[2*CODE_W +: CODE_W];
            3'd3:    res = row[3*CODE_W +: CODE_W];
            3'd4:    res = row[4*CODE_W +: CODE_W];
            default: res = '0;
        endcase
        return res;
    endfunction

    // Move one place forward (encrypt) or back (decrypt), wrapping at the edge
    function automatic idx_t step_idx(input idx_t idx, input logic decrypt);
        idx_t res;
        if (decrypt) begin
            res = (idx == IDX_FIRST) ? IDX_LAST : idx - 3'd1;
        end else begin
            res = (idx == IDX_LAST) ? IDX_FIRST : idx + 3'd1;
        end
        return res;
    endfunction

endpackage

FILE: sv/pdc_row_lane.sv
module pdc_row_lane
    import pdc_pkg::*;
(
    input  row_t      row,
    input  letter_t   letter_a,
    input  letter_t   letter_b,
    output lane_hit_t hit
);

    letter_t key_a;
    letter_t key_b;
    logic    ok_a;
    logic    ok_b;

    // Look J up as I; codes above Z never match
    always_comb begin
        key_a = (letter_a == CODE_J) ? CODE_I : letter_a;
        key_b = (letter_b == CODE_J) ? CODE_I : letter_b;
        ok_a  = (key_a <= CODE_MAX);
        ok_b  = (key_b <= CODE_MAX);
    end

    // Search the row, keeping the last matching column
    always_comb begin
        hit = '0;
        for (int c = 0; c < SQ_DIM; c++) begin
            if (ok_a && (cell_of(row, idx_t'(c)) == key_a)) begin
                hit.hit_a = 1'b1;
                hit.col_a = idx_t'(c);
            end
            if (ok_b && (cell_of(row, idx_t'(c)) == key_b)) begin
                hit.hit_b = 1'b1;
                hit.col_b = idx_t'(c);
            end
        end
    end

endmodule

FILE: sv/pdc_merge.sv
module pdc_merge
    import pdc_pkg::*;
(
    input  row_t      rows [SQ_DIM],
    input  lane_hit_t hits [SQ_DIM],
    input  logic      decrypt,
    output letter_t   out_first,
    output letter_t   out_second,
    output logic      letter_missing
);

    logic found_a;
    logic found_b;
    idx_t row_a;
    idx_t col_a;
    idx_t row_b;
    idx_t col_b;

    // Pick the last row whose lane reports a match
    always_comb begin
        found_a = 1'b0;
        found_b = 1'b0;
        row_a   = '0;
        col_a   = '0;
        row_b   = '0;
        col_b   = '0;
        for (int r = 0; r < SQ_DIM; r++) begin
            if (hits[r].hit_a) begin
                found_a = 1'b1;
                row_a   = idx_t'(r);
                col_a   = hits[r].col_a;
            end
            if (hits[r].hit_b) begin
                found_b = 1'b1;
                row_b   = idx_t'(r);
                col_b   = hits[r].col_b;
            end
        end
    end

    // Apply the row, column or rectangle rule, or flag a missing letter
    always_comb begin
        out_first      = '0;
        out_second     = '0;
        letter_missing = 1'b0;
        if (!(found_a && found_b)) begin
            letter_missing = 1'b1;
        end else if (row_a == row_b) begin
            out_first  = cell_of(rows[row_a], step_idx(col_a, decrypt));
            out_second = cell_of(rows[row_b], step_idx(col_b, decrypt));
        end else if (col_a == col_b) begin
            out_first  = cell_of(rows[step_idx(row_a, decrypt)], col_a);
            out_second = cell_of(rows[step_idx(row_b, decrypt)], col_b);
        end else begin
            out_first  = cell_of(rows[row_a], col_b);
            out_second = cell_of(rows[row_b], col_a);
        end
    end

endmodule

FILE: sv/playfair_digram_cipher.sv
// Playfair digram cipher over a 5x5 key square held in five row registers.
//
// Input stream: s_tdata carries two letter codes (A=0 .. Z=25), s_tuser
// selects encrypt (0) or decrypt (1). Output stream: m_tdata carries the two
// transformed letters, m_tuser flags a letter that is not in the square, in
// which case both letters read as zero. J is looked up as I.
// Key square rows are written over the APB port at byte addresses 0, 4, 8,
// 12 and 16, five 5-bit codes each, column 0 in the low bits; only write
// them while no word is in flight.
// Throughput: one digram per cycle while the receiver does not stall. The row
// lanes' register takes the word at the accepting edge; the output register
// then takes the merged result and presents it with m_tvalid.
// Five row lanes search their rows in parallel; the merge stage picks the
// matching rows and applies the shift or corner swap.
// Reset clears the square to all zeros and empties the pipeline. When the
// receiver stalls, the pipeline holds and s_tready falls once both stages
// are full; no word is dropped.
module playfair_digram_cipher
    import pdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] first_letter, [9:5] second_letter, [15:10] zero
    input  logic        s_tuser,   // [0] action
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] out_first, [9:5] out_second, [15:10] zero
    output logic        m_tuser,   // [0] letter_missing
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    row_t      rows_reg [SQ_DIM];
    lane_hit_t hits_comb [SQ_DIM];
    lane_hit_t hits_reg [SQ_DIM];
    logic      act_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    letter_t   first_comb;
    letter_t   second_comb;
    logic      missing_comb;
    letter_t   first_reg;
    letter_t   second_reg;
    logic      missing_reg;
    logic      adv_out;
    logic      adv_s1;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_DIM; i++) begin
                rows_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROW_A: rows_reg[0] <= pwdata[ROW_W-1:0];
                REG_ROW_B: rows_reg[1] <= pwdata[ROW_W-1:0];
                REG_ROW_C: rows_reg[2] <= pwdata[ROW_W-1:0];
                REG_ROW_D: rows_reg[3] <= pwdata[ROW_W-1:0];
                REG_ROW_E: rows_reg[4] <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_ROW_A: prdata = {7'd0, rows_reg[0]};
            REG_ROW_B: prdata = {7'd0, rows_reg[1]};
            REG_ROW_C: prdata = {7'd0, rows_reg[2]};
            REG_ROW_D: prdata = {7'd0, rows_reg[3]};
            REG_ROW_E: prdata = {7'd0, rows_reg[4]};
            default:   prdata = '0;
        endcase
    end

    // Pipeline flow: advance a stage when the one after it can take a word
    assign adv_out  = !m_valid_reg || m_tready;
    assign adv_s1   = !s1_valid_reg || adv_out;
    assign s_tready = adv_s1;

    assign s1_valid_next = adv_s1 ? s_tvalid : s1_valid_reg;
    assign m_valid_next  = adv_out ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Row lanes
    for (genvar g = 0; g < SQ_DIM; g++) begin : g_lane
        pdc_row_lane u_lane (
            .row      (rows_reg[g]),
            .letter_a (s_tdata[4:0]),
            .letter_b (s_tdata[9:5]),
            .hit      (hits_comb[g])
        );
    end

    // Hold lane results for the merge stage
    always_ff @(posedge aclk) begin
        if (adv_s1) begin
            hits_reg <= hits_comb;
            act_reg  <= s_tuser;
        end
    end

    pdc_merge u_merge (
        .rows           (rows_reg),
        .hits           (hits_reg),
        .decrypt        (act_reg),
        .out_first      (first_comb),
        .out_second     (second_comb),
        .letter_missing (missing_comb)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (adv_out) begin
            first_reg   <= first_comb;
            second_reg  <= second_comb;
            missing_reg <= missing_comb;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, second_reg, first_reg};
    assign m_tuser  = missing_reg;

endmodule

FILE: sv/pdc_checker.sv
module pdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A missing letter gives zero letters
    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("letters not cleared on missing letter");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A free output always lets the input side take a word
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind playfair_digram_cipher pdc_checker u_pdc_checker (.*);
